// ----- hw/rtl/usb_descriptor_parser_defines.svh -----
// Assertion macros for the USB descriptor parser.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef USB_DESCRIPTOR_PARSER_DEFINES_SVH
`define USB_DESCRIPTOR_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define USBDP_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("usbdp assertion failed");
`define USBDP_ASSERT(label, prop) `USBDP_ASSERT_CLK(label, i_clk, i_rst_n, prop)
`else
`define USBDP_ASSERT_CLK(label, clk, rst_n, prop)
`define USBDP_ASSERT(label, prop)
`endif
`endif

// ----- hw/rtl/usbdp_pkg.sv -----
// Types and constants shared by the USB descriptor parser modules.
// Depends on nothing.
package usbdp_pkg;

    localparam logic [7:0] DEVICE_MIN_LEN = 8'd18;
    localparam logic [7:0] LONG_DESC_MIN  = 8'd9;
    localparam logic [7:0] EP_DESC_MIN    = 8'd7;
    localparam logic [7:0] DESC_MIN       = 8'd2;
    localparam int         FIELD_DEPTH    = 10;
    localparam int         REQ_W          = 17;
    localparam int         QUEUE_DEPTH    = 4;
    localparam int         QPTR_W         = 2;

    localparam logic [7:0] DESC_DEVICE    = 8'd1;
    localparam logic [7:0] DESC_CONFIG    = 8'd2;
    localparam logic [7:0] DESC_INTERFACE = 8'd4;
    localparam logic [7:0] DESC_ENDPOINT  = 8'd5;

    typedef enum logic [2:0] {
        KIND_DEVICE    = 3'd0,
        KIND_CONFIG    = 3'd1,
        KIND_INTERFACE = 3'd2,
        KIND_ENDPOINT  = 3'd3,
        KIND_STATUS    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [7:0]  class_f;
        logic [7:0]  subclass_f;
        logic [7:0]  protocol_f;
        logic [7:0]  extra_f;
        logic        accepted;
    } t_record;

    typedef struct packed {
        logic    rec_valid;
        t_record rec;
        logic    stat_valid;
        t_record stat;
    } t_event;

endpackage

// ----- hw/rtl/usbdp_channels.sv -----
// Handshake channels of the USB descriptor parser: blob bytes in, records out.
// Depends on nothing.
interface usbdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;
    modport source(output valid, data_byte, final_byte, input ready);
    modport sink(input valid, data_byte, final_byte, output ready);
endinterface

interface usbdp_rec_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [7:0]  class_field;
    logic [7:0]  subclass_field;
    logic [7:0]  protocol_field;
    logic [7:0]  extra_field;
    logic        accepted;
    logic        run_last;
    modport source(output valid, record_kind, value_a, value_b, class_field,
                   subclass_field, protocol_field, extra_field, accepted, run_last,
                   input ready);
    modport sink(input valid, record_kind, value_a, value_b, class_field,
                 subclass_field, protocol_field, extra_field, accepted, run_last,
                 output ready);
endinterface

// ----- hw/rtl/usbdp_front.sv -----
// Front end: walks the descriptor chain one byte per cycle while the event queue is not full, and emits events.
// Depends on usbdp_pkg and usbdp_byte_if.
module usbdp_front #(
    parameter int MAX_BLOB_BYTES = 512,
    parameter int MAX_INTERFACES = 16,
    parameter int MAX_ENDPOINTS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    usbdp_byte_if.sink            i_byte,
    input  logic                  i_q_full,
    output logic                  o_push,
    output usbdp_pkg::t_event     o_event
);
    localparam int OFS_W = $clog2(MAX_BLOB_BYTES + 1);
    localparam int IF_W  = $clog2(MAX_INTERFACES + 1);
    localparam int EP_W  = $clog2(MAX_ENDPOINTS + 1);
    localparam int RW    = usbdp_pkg::REQ_W;

    logic [OFS_W-1:0] r_ofs, n_ofs;
    logic             r_too_long, n_too_long;
    logic [7:0]       r_pos, n_pos;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_kind, n_kind;
    logic [7:0]       r_fb [usbdp_pkg::FIELD_DEPTH];
    logic [7:0]       n_fb [usbdp_pkg::FIELD_DEPTH];
    logic [IF_W-1:0]  r_if_total, n_if_total;
    logic [EP_W-1:0]  r_ep_total, n_ep_total;
    logic             r_have_if, n_have_if;
    logic [7:0]       r_cur_if, n_cur_if;
    logic [7:0]       r_cfg, n_cfg;
    logic [RW-1:0]    r_req, n_req;
    logic             r_failed, n_failed;

    logic              accept;
    logic [7:0]        b;
    logic [7:0]        pos_inc;
    logic [RW-1:0]     start;
    logic [RW-1:0]     cfg_end;
    logic [15:0]       total;
    logic              ok;
    usbdp_pkg::t_event evt;

    assign accept = i_byte.valid && i_byte.ready;
    assign b      = i_byte.data_byte;
    assign i_byte.ready = !i_q_full;

    always_comb begin
        n_ofs      = r_ofs;
        n_too_long = r_too_long;
        n_pos      = r_pos;
        n_len      = r_len;
        n_kind     = r_kind;
        n_fb       = r_fb;
        n_if_total = r_if_total;
        n_ep_total = r_ep_total;
        n_have_if  = r_have_if;
        n_cur_if   = r_cur_if;
        n_cfg      = r_cfg;
        n_req      = r_req;
        n_failed   = r_failed;
        pos_inc    = r_pos + 8'd1;
        start      = RW'(r_ofs) + RW'(1) - RW'(r_len);
        total      = '0;
        cfg_end    = '0;
        ok         = 1'b0;
        evt        = '0;

        if (!r_failed) begin
            if (r_ofs >= OFS_W'(MAX_BLOB_BYTES)) begin
                n_too_long = 1'b1;
                n_failed   = 1'b1;
            end else begin
                n_ofs = r_ofs + 1'b1;
                if ((r_ofs == '0 && b < usbdp_pkg::DEVICE_MIN_LEN) ||
                    (r_ofs == OFS_W'(1) && b != usbdp_pkg::DESC_DEVICE)) begin
                    n_failed = 1'b1;
                end else if (r_pos == '0) begin
                    if (b < usbdp_pkg::DESC_MIN) begin
                        n_failed = 1'b1;
                    end else begin
                        n_len = b;
                        n_pos = 8'd1;
                    end
                end else begin
                    if (r_pos == 8'd1) begin
                        n_kind = b;
                    end
                    for (int i = 0; i < usbdp_pkg::FIELD_DEPTH; i++) begin
                        if (r_pos == 8'(i + 2)) begin
                            n_fb[i] = b;
                        end
                    end
                    n_pos = pos_inc;
                    if (pos_inc == r_len) begin
                        n_pos = '0;
                        total = {n_fb[1], n_fb[0]};
                        if (start == '0) begin
                            evt.rec_valid       = 1'b1;
                            evt.rec.kind        = usbdp_pkg::KIND_DEVICE;
                            evt.rec.value_a     = {n_fb[7], n_fb[6]};
                            evt.rec.value_b     = {n_fb[9], n_fb[8]};
                            evt.rec.class_f     = n_fb[2];
                            evt.rec.subclass_f  = n_fb[3];
                            evt.rec.protocol_f  = n_fb[4];
                            evt.rec.extra_f     = n_fb[5];
                        end else if (n_kind == usbdp_pkg::DESC_CONFIG &&
                                     r_len >= usbdp_pkg::LONG_DESC_MIN) begin
                            cfg_end = start + RW'(total);
                            if (total != '0 && cfg_end > r_req) begin
                                n_req = cfg_end;
                            end
                            n_cfg               = n_fb[3];
                            evt.rec_valid       = 1'b1;
                            evt.rec.kind        = usbdp_pkg::KIND_CONFIG;
                            evt.rec.value_a     = 16'(n_fb[3]);
                            evt.rec.value_b     = total;
                        end else if (n_kind == usbdp_pkg::DESC_INTERFACE &&
                                     r_len >= usbdp_pkg::LONG_DESC_MIN) begin
                            if (r_if_total >= IF_W'(MAX_INTERFACES)) begin
                                n_failed = 1'b1;
                            end else begin
                                n_if_total          = r_if_total + 1'b1;
                                n_have_if           = 1'b1;
                                n_cur_if            = n_fb[0];
                                evt.rec_valid       = 1'b1;
                                evt.rec.kind        = usbdp_pkg::KIND_INTERFACE;
                                evt.rec.value_a     = 16'(n_fb[0]);
                                evt.rec.value_b     = 16'(n_fb[1]);
                                evt.rec.class_f     = n_fb[3];
                                evt.rec.subclass_f  = n_fb[4];
                                evt.rec.protocol_f  = n_fb[5];
                                evt.rec.extra_f     = n_fb[2];
                            end
                        end else if (n_kind == usbdp_pkg::DESC_ENDPOINT &&
                                     r_len >= usbdp_pkg::EP_DESC_MIN) begin
                            if (!r_have_if || r_ep_total >= EP_W'(MAX_ENDPOINTS)) begin
                                n_failed = 1'b1;
                            end else begin
                                n_ep_total          = r_ep_total + 1'b1;
                                evt.rec_valid       = 1'b1;
                                evt.rec.kind        = usbdp_pkg::KIND_ENDPOINT;
                                evt.rec.value_a     = 16'(n_fb[0]);
                                evt.rec.value_b     = {n_fb[3], n_fb[2]};
                                evt.rec.class_f     = n_fb[1];
                                evt.rec.subclass_f  = n_fb[4];
                                evt.rec.protocol_f  = r_cur_if;
                            end
                        end
                    end
                end
            end
        end

        if (i_byte.final_byte) begin
            ok = !n_failed && !n_too_long && n_pos == '0 &&
                 n_ofs >= OFS_W'(usbdp_pkg::DEVICE_MIN_LEN) &&
                 n_req <= RW'(n_ofs) && n_cfg != '0;
            evt.stat_valid     = 1'b1;
            evt.stat.kind      = usbdp_pkg::KIND_STATUS;
            evt.stat.value_a   = 16'(n_cfg);
            evt.stat.value_b   = 16'(n_if_total);
            evt.stat.class_f   = 8'(n_ep_total);
            evt.stat.accepted  = ok;
            // restart for the next blob
            n_ofs      = '0;
            n_too_long = 1'b0;
            n_pos      = '0;
            n_len      = '0;
            n_kind     = '0;
            n_if_total = '0;
            n_ep_total = '0;
            n_have_if  = 1'b0;
            n_cur_if   = '0;
            n_cfg      = '0;
            n_req      = '0;
            n_failed   = 1'b0;
        end
    end

    assign o_push  = accept && (evt.rec_valid || evt.stat_valid);
    assign o_event = evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs      <= '0;
            r_too_long <= 1'b0;
            r_pos      <= '0;
            r_len      <= '0;
            r_kind     <= '0;
            r_if_total <= '0;
            r_ep_total <= '0;
            r_have_if  <= 1'b0;
            r_cur_if   <= '0;
            r_cfg      <= '0;
            r_req      <= '0;
            r_failed   <= 1'b0;
        end else if (accept) begin
            r_ofs      <= n_ofs;
            r_too_long <= n_too_long;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_kind     <= n_kind;
            r_if_total <= n_if_total;
            r_ep_total <= n_ep_total;
            r_have_if  <= n_have_if;
            r_cur_if   <= n_cur_if;
            r_cfg      <= n_cfg;
            r_req      <= n_req;
            r_failed   <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fb <= n_fb;
        end
    end

endmodule

// ----- hw/rtl/usbdp_queue.sv -----
// Short event queue between the parsing front end and the record back end.
// Depends on usbdp_pkg.
module usbdp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  usbdp_pkg::t_event i_data,
    input  logic              i_pop,
    output usbdp_pkg::t_event o_data,
    output logic              o_full,
    output logic              o_empty
);
    localparam int PW = usbdp_pkg::QPTR_W;

    usbdp_pkg::t_event r_mem [usbdp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     r_wr, r_rd;
    logic [PW:0]       r_count;

    assign o_full  = r_count == (PW + 1)'(usbdp_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/usbdp_back.sv -----
// Back end: expands each event into one or two output records.
// Depends on usbdp_pkg and usbdp_rec_if.
module usbdp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  usbdp_pkg::t_event i_q_data,
    output logic              o_pop,
    usbdp_rec_if.source       o_rec
);
    usbdp_pkg::t_event  r_evt;
    logic               r_busy;
    logic               r_second;
    usbdp_pkg::t_record cur;
    logic               cur_last;
    logic               done;

    always_comb begin
        if (!r_second && r_evt.rec_valid) begin
            cur      = r_evt.rec;
            cur_last = !r_evt.stat_valid;
        end else begin
            cur      = r_evt.stat;
            cur_last = 1'b1;
        end
    end

    assign done  = r_busy && o_rec.ready;
    assign o_pop = i_q_valid && (!r_busy || (done && cur_last));

    assign o_rec.valid          = r_busy;
    assign o_rec.record_kind    = cur.kind;
    assign o_rec.value_a        = cur.value_a;
    assign o_rec.value_b        = cur.value_b;
    assign o_rec.class_field    = cur.class_f;
    assign o_rec.subclass_field = cur.subclass_f;
    assign o_rec.protocol_field = cur.protocol_f;
    assign o_rec.extra_field    = cur.extra_f;
    assign o_rec.accepted       = cur.accepted;
    assign o_rec.run_last       = cur_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_evt <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
        end else if (o_pop) begin
            r_busy   <= 1'b1;
            r_second <= 1'b0;
        end else if (done) begin
            if (cur_last) begin
                r_busy <= 1'b0;
            end else begin
                r_second <= 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/usb_descriptor_parser.sv -----
// USB descriptor parser top level: front end, event queue, back end.
// Depends on usbdp_pkg, usbdp_channels, usbdp_front, usbdp_queue, usbdp_back.
//
// Takes one blob byte per cycle and emits device, configuration, interface
// and endpoint records plus a status record on the final byte. Each byte is
// parsed in the cycle it is accepted; records reach the output one per
// cycle while the output is ready, from a four-entry event queue, so a byte
// that completes a descriptor and also ends the blob yields two records.
// Input ready drops only while that queue is full. A byte's event is
// registered in the queue and then in the back end before its first record.
`include "usb_descriptor_parser_defines.svh"
module usb_descriptor_parser #(
    parameter int MAX_BLOB_BYTES = 512,
    parameter int MAX_INTERFACES = 16,
    parameter int MAX_ENDPOINTS  = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    usbdp_byte_if.sink   i_byte,
    usbdp_rec_if.source  o_rec
);
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    usbdp_pkg::t_event q_in;
    usbdp_pkg::t_event q_out;

    usbdp_front #(
        .MAX_BLOB_BYTES(MAX_BLOB_BYTES),
        .MAX_INTERFACES(MAX_INTERFACES),
        .MAX_ENDPOINTS (MAX_ENDPOINTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_q_full(q_full),
        .o_push  (q_push),
        .o_event (q_in)
    );

    usbdp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    usbdp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(!q_empty),
        .i_q_data (q_out),
        .o_pop    (q_pop),
        .o_rec    (o_rec)
    );

    `USBDP_ASSERT(a_no_overflow, q_push |-> !q_full)
    `USBDP_ASSERT(a_no_underflow, q_pop |-> !q_empty)
    `USBDP_ASSERT(a_final_queued, (i_byte.valid && i_byte.ready && i_byte.final_byte) |=> !q_empty)
    `USBDP_ASSERT(a_status_last, (o_rec.valid && o_rec.record_kind == usbdp_pkg::KIND_STATUS) |-> o_rec.run_last)
    `USBDP_ASSERT(a_accept_in_status, (o_rec.valid && o_rec.accepted) |-> (o_rec.record_kind == usbdp_pkg::KIND_STATUS))

endmodule
